### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed: next-cycle implication");

`endif

### src/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Types, constants and helpers shared by the page allocator modules.
// ----------------------------------------------------------------------------
package pta_pkg;

	localparam int PAGE_BYTES     = 256;
	localparam int PAGE_LOG2      = 8;
	localparam int NUM_PAGES      = 16;
	localparam int PAGE_W         = 4;
	localparam int MIN_BLOCK_LOG2 = 3;
	localparam int GRANULES       = 512;
	localparam int GRAN_W         = 9;
	localparam int LINK_W         = 10;
	localparam int NUM_HEADS      = 8;
	localparam int HEAD_W         = 3;
	localparam int CLS_W          = 4;
	localparam int POW_W          = 4;
	localparam int ADDR_W         = 12;
	localparam int SIZE_W         = 13;
	localparam int SUM_W          = 32;
	localparam int RUN_W          = 7;
	localparam int BLK_W          = 5;

	localparam logic [CLS_W-1:0] RUN_TAIL = 4'd15;
	localparam logic             OP_ALLOC = 1'b0;
	localparam logic             OP_FREE  = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] block_address;
	} pta_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic              success;
		logic [SUM_W-1:0]  requested_bytes_total;
		logic [SUM_W-1:0]  allocated_bytes_total;
	} pta_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_SPLIT,
		ST_POP_RD,
		ST_POP_WR,
		ST_TAKE,
		ST_FREE_RUN,
		ST_DONE_OK,
		ST_DONE_FAIL
	} pta_state_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic split_init;
		logic split_step;
		logic pop_rd;
		logic pop_wr;
		logic take_init;
		logic take_step;
		logic free_small;
		logic free_run_init;
		logic free_run_step;
		logic result_wr;
		logic result_ok;
	} pta_cmd_t;

	typedef struct packed {
		logic is_free;
		logic is_small;
		logic too_big;
		logic head_empty;
		logic scan_hit;
		logic scan_end;
		logic split_last;
		logic sweep_last;
		logic free_bad;
		logic free_small;
		logic out_full;
	} pta_sts_t;

	function automatic logic [POW_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
		logic [POW_W-1:0] p;
		p = POW_W'(SIZE_W);
		for (int i = SIZE_W; i >= 0; i--) begin
			if (((SIZE_W+1)'(1) << i) >= {1'b0, v})
				p = POW_W'(i);
		end
		return p;
	endfunction

endpackage

### src/power_of_two_page_allocator.sv
// ----------------------------------------------------------------------------
// power_of_two_page_allocator
// Power-of-two page allocator: small classes on LIFO lists, page runs by scan.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  req     | req_valid/req_stall  | req (operation, request_size, block_address)
//  rsp     | rsp_valid/rsp_stall  | rsp (address, success, byte totals)
//
//  One item at a time. Free: decode, then release of each page of a run, then
//  result. Small alloc from a list: decode, pop read, pop write, result; on an
//  empty list a scan of up to 16 pages and a split into up to 32 blocks come
//  first. Run alloc: decode, scan of up to 16 pages, take of each page, result.
//  Reset frees all pages and clears classes, list heads and totals; no clearing pass.
//  A stalled result holds; the next item is taken while it waits.
// ----------------------------------------------------------------------------
module power_of_two_page_allocator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  pta_pkg::pta_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output pta_pkg::pta_rsp_t rsp
);
	import pta_pkg::*;

	`include "assert_macros.svh"

	pta_cmd_t cmd;
	pta_sts_t sts;

	pta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pta_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	`ASSERT_IMPL(a_fail_zero_addr, rsp_valid && !rsp.success, rsp.result_address == '0)
	`ASSERT_IMPL(a_alloc_ge_req, rsp_valid,
		rsp.allocated_bytes_total >= rsp.requested_bytes_total)

endmodule

### src/pta_ctrl.sv
// ----------------------------------------------------------------------------
// pta_ctrl
// Sequencer: decode, page scan, split, pop, run take and run release.
// ----------------------------------------------------------------------------
module pta_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  pta_pkg::pta_sts_t sts,
	output pta_pkg::pta_cmd_t cmd
);
	import pta_pkg::*;

	pta_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_free) begin
					if (sts.free_bad) begin
						state_d = ST_DONE_FAIL;
					end else if (sts.free_small) begin
						cmd.free_small = 1'b1;
						state_d        = ST_DONE_OK;
					end else begin
						cmd.free_run_init = 1'b1;
						state_d           = ST_FREE_RUN;
					end
				end else if (sts.is_small) begin
					if (sts.head_empty) begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_SCAN;
					end else begin
						state_d = ST_POP_RD;
					end
				end else if (sts.too_big) begin
					state_d = ST_DONE_FAIL;
				end else begin
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_hit) begin
					if (sts.is_small) begin
						cmd.split_init = 1'b1;
						state_d        = ST_SPLIT;
					end else begin
						cmd.take_init = 1'b1;
						state_d       = ST_TAKE;
					end
				end else if (sts.scan_end) begin
					state_d = ST_DONE_FAIL;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_SPLIT: begin
				cmd.split_step = 1'b1;
				if (sts.split_last)
					state_d = ST_POP_RD;
			end
			ST_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d    = ST_POP_WR;
			end
			ST_POP_WR: begin
				cmd.pop_wr = 1'b1;
				state_d    = ST_DONE_OK;
			end
			ST_TAKE: begin
				cmd.take_step = 1'b1;
				if (sts.sweep_last)
					state_d = ST_DONE_OK;
			end
			ST_FREE_RUN: begin
				cmd.free_run_step = 1'b1;
				if (sts.sweep_last)
					state_d = ST_DONE_OK;
			end
			ST_DONE_OK: begin
				if (!sts.out_full) begin
					cmd.result_wr = 1'b1;
					cmd.result_ok = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_DONE_FAIL: begin
				if (!sts.out_full) begin
					cmd.result_wr = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### src/pta_datapath.sv
// ----------------------------------------------------------------------------
// pta_datapath
// Page map, size classes, list heads, link memory, totals and result register.
// ----------------------------------------------------------------------------
module pta_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  pta_pkg::pta_req_t req,
	input  pta_pkg::pta_cmd_t cmd,
	output pta_pkg::pta_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output pta_pkg::pta_rsp_t rsp
);
	import pta_pkg::*;

	logic                op_q;
	logic [SIZE_W-1:0]   size_q;
	logic [ADDR_W-1:0]   baddr_q;
	logic [POW_W-1:0]    pow_q;

	logic [NUM_PAGES-1:0] free_map_q;
	logic [CLS_W-1:0]     cls_q [NUM_PAGES];
	logic [LINK_W-1:0]    head_q [NUM_HEADS];
	logic [LINK_W-1:0]    link_mem [GRANULES];
	logic [LINK_W-1:0]    lk_rd_q;

	logic [PAGE_W-1:0]   pg_q;
	logic [BLK_W:0]      run_cnt_q;
	logic [PAGE_W-1:0]   split_pg_q;
	logic [GRAN_W-1:0]   here_q;
	logic [BLK_W-1:0]    blk_q;
	logic [PAGE_W-1:0]   sweep_q;
	logic [PAGE_W-1:0]   end_q;
	logic [PAGE_W-1:0]   start_q;
	logic [GRAN_W-1:0]   g_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [SUM_W-1:0]    req_sum_q;
	logic [SUM_W-1:0]    alloc_sum_q;
	logic                rsp_valid_q;
	pta_rsp_t            rsp_q;

	logic [POW_W-1:0]    req_pow;
	logic [HEAD_W-1:0]   a_ci;
	logic                a_small;
	logic [RUN_W-1:0]    a_n;
	logic [SIZE_W:0]     rounded;
	logic [GRAN_W-1:0]   step;
	logic [BLK_W-1:0]    cnt_m1;
	logic                split_last;

	logic [PAGE_W-1:0]   f_pg;
	logic [CLS_W-1:0]    f_cls;
	logic [HEAD_W-1:0]   f_ci;
	logic [GRAN_W:0]     f_one;
	logic [GRAN_W-1:0]   f_g;
	logic [RUN_W-1:0]    f_n;
	logic [RUN_W-1:0]    f_end_w;
	logic [PAGE_W-1:0]   f_end;
	logic                map_bit;

	logic                lk_we;
	logic [GRAN_W-1:0]   lk_wa;
	logic [LINK_W-1:0]   lk_wd;
	logic [SUM_W:0]      req_sum_n;
	logic [SUM_W:0]      alloc_sum_n;

	always_comb begin
		req_pow = ceil_log2(req.request_size);
		if (req_pow < POW_W'(MIN_BLOCK_LOG2))
			req_pow = POW_W'(MIN_BLOCK_LOG2);
	end

	assign a_ci       = HEAD_W'(pow_q - POW_W'(MIN_BLOCK_LOG2));
	assign a_small    = pow_q < POW_W'(PAGE_LOG2);
	assign a_n        = RUN_W'(1) << (pow_q - POW_W'(PAGE_LOG2));
	assign rounded    = (SIZE_W+1)'(1) << pow_q;
	assign step       = GRAN_W'(1) << (pow_q - POW_W'(MIN_BLOCK_LOG2));
	assign cnt_m1     = BLK_W'(((GRAN_W+1)'(PAGE_BYTES) >> pow_q) - 1'b1);
	assign split_last = (blk_q == cnt_m1);

	assign f_pg    = baddr_q[ADDR_W-1 -: PAGE_W];
	assign f_cls   = cls_q[f_pg];
	assign f_ci    = HEAD_W'(f_cls - CLS_W'(MIN_BLOCK_LOG2));
	assign f_one   = (GRAN_W+1)'(1) << (f_cls - CLS_W'(MIN_BLOCK_LOG2));
	assign f_g     = baddr_q[ADDR_W-1:MIN_BLOCK_LOG2] & ~GRAN_W'(f_one - 1'b1);
	assign f_n     = RUN_W'(1) << (f_cls - CLS_W'(PAGE_LOG2));
	assign f_end_w = RUN_W'(f_pg) + f_n - 1'b1;
	assign f_end   = (f_end_w > RUN_W'(NUM_PAGES - 1)) ? PAGE_W'(NUM_PAGES - 1)
	                                                    : PAGE_W'(f_end_w);

	assign map_bit = free_map_q[(op_q == OP_FREE) ? f_pg : pg_q];

	always_comb begin
		sts            = '0;
		sts.is_free    = (op_q == OP_FREE);
		sts.is_small   = a_small;
		sts.too_big    = a_n > RUN_W'(NUM_PAGES);
		sts.head_empty = head_q[a_ci][LINK_W-1];
		sts.scan_hit   = map_bit && (a_small || (RUN_W'(run_cnt_q) + 1'b1 == a_n));
		sts.scan_end   = (pg_q == PAGE_W'(NUM_PAGES - 1));
		sts.split_last = split_last;
		sts.sweep_last = (sweep_q == end_q);
		sts.free_bad   = map_bit || (f_cls == RUN_TAIL) ||
		                 (f_cls < CLS_W'(MIN_BLOCK_LOG2));
		sts.free_small = f_cls < CLS_W'(PAGE_LOG2);
		sts.out_full   = rsp_valid_q && rsp_stall;
	end

	assign lk_we = cmd.split_step || cmd.free_small;
	assign lk_wa = cmd.split_step ? here_q : f_g;
	always_comb begin
		if (cmd.split_step)
			lk_wd = split_last ? LINK_W'(GRANULES) : {1'b0, here_q + step};
		else
			lk_wd = head_q[f_ci];
	end

	always_ff @(posedge clk) begin
		if (lk_we)
			link_mem[lk_wa] <= lk_wd;
		lk_rd_q <= link_mem[head_q[a_ci][GRAN_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req.operation;
			size_q  <= req.request_size;
			baddr_q <= req.block_address;
			pow_q   <= req_pow;
		end
		if (cmd.scan_clr) begin
			pg_q      <= '0;
			run_cnt_q <= '0;
		end else if (cmd.scan_step) begin
			pg_q      <= pg_q + 1'b1;
			run_cnt_q <= map_bit ? run_cnt_q + 1'b1 : '0;
		end
		if (cmd.split_init) begin
			split_pg_q <= pg_q;
			here_q     <= {pg_q, (GRAN_W-PAGE_W)'(0)};
			blk_q      <= '0;
		end else if (cmd.split_step) begin
			here_q <= here_q + step;
			blk_q  <= blk_q + 1'b1;
		end
		if (cmd.take_init) begin
			start_q <= PAGE_W'(pg_q - PAGE_W'(a_n - 1'b1));
			sweep_q <= PAGE_W'(pg_q - PAGE_W'(a_n - 1'b1));
			end_q   <= pg_q;
			addr_q  <= {PAGE_W'(pg_q - PAGE_W'(a_n - 1'b1)), PAGE_LOG2'(0)};
		end else if (cmd.free_run_init) begin
			sweep_q <= f_pg;
			end_q   <= f_end;
		end else if (cmd.take_step || cmd.free_run_step) begin
			sweep_q <= sweep_q + 1'b1;
		end
		if (cmd.pop_rd)
			g_q <= head_q[a_ci][GRAN_W-1:0];
		if (cmd.pop_wr)
			addr_q <= {g_q, MIN_BLOCK_LOG2'(0)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_map_q <= '1;
			for (int i = 0; i < NUM_PAGES; i++)
				cls_q[i] <= '0;
			for (int i = 0; i < NUM_HEADS; i++)
				head_q[i] <= LINK_W'(GRANULES);
		end else begin
			if (cmd.split_step && split_last) begin
				free_map_q[split_pg_q] <= 1'b0;
				cls_q[split_pg_q]      <= pow_q;
				head_q[a_ci]           <= {1'b0, split_pg_q, (GRAN_W-PAGE_W)'(0)};
			end
			if (cmd.pop_wr)
				head_q[a_ci] <= lk_rd_q;
			if (cmd.free_small)
				head_q[f_ci] <= {1'b0, f_g};
			if (cmd.take_step) begin
				free_map_q[sweep_q] <= 1'b0;
				cls_q[sweep_q]      <= (sweep_q == start_q) ? pow_q : RUN_TAIL;
			end
			if (cmd.free_run_step) begin
				free_map_q[sweep_q] <= 1'b1;
				cls_q[sweep_q]      <= '0;
			end
		end
	end

	assign req_sum_n   = {1'b0, req_sum_q} + (SUM_W+1)'(size_q);
	assign alloc_sum_n = {1'b0, alloc_sum_q} + (SUM_W+1)'(rounded);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_sum_q   <= '0;
			alloc_sum_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.result_wr) begin
				rsp_valid_q <= 1'b1;
				if (cmd.result_ok && op_q == OP_ALLOC) begin
					req_sum_q   <= req_sum_n[SUM_W] ? '1 : req_sum_n[SUM_W-1:0];
					alloc_sum_q <= alloc_sum_n[SUM_W] ? '1 : alloc_sum_n[SUM_W-1:0];
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_wr) begin
			rsp_q.success        <= cmd.result_ok;
			rsp_q.result_address <= (cmd.result_ok && op_q == OP_ALLOC) ? addr_q : '0;
			if (cmd.result_ok && op_q == OP_ALLOC) begin
				rsp_q.requested_bytes_total <= req_sum_n[SUM_W] ? '1
				                                                : req_sum_n[SUM_W-1:0];
				rsp_q.allocated_bytes_total <= alloc_sum_n[SUM_W] ? '1
				                                                  : alloc_sum_n[SUM_W-1:0];
			end else begin
				rsp_q.requested_bytes_total <= req_sum_q;
				rsp_q.allocated_bytes_total <= alloc_sum_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
